// ===== design/sps_pkg.sv =====
// shared codes, phase table and types for the stepper phase sequencer
package sps_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_START   = 2'd1;
   localparam logic [1:0] OP_BREAK   = 2'd2;
   localparam logic [1:0] OP_RELEASE = 2'd3;

   localparam logic [1:0] MODE_TWO_WIRE  = 2'd0;
   localparam logic [1:0] MODE_SINGLE    = 2'd1;
   localparam logic [1:0] MODE_DOUBLE    = 2'd2;
   localparam logic [1:0] MODE_HALF_STEP = 2'd3;

   localparam logic [1:0] REG_DRIVE_MODE  = 2'd0;
   localparam logic [1:0] REG_DIRECTION   = 2'd1;
   localparam logic [1:0] REG_STEP_PERIOD = 2'd2;

   localparam logic [15:0] STEP_PERIOD_RESET = 16'd1000;
   localparam logic [15:0] STEP_PERIOD_MIN   = 16'd2;

   typedef struct packed {
      logic [3:0]  phase_bits;
      logic        step_taken;
      logic        finished;
      logic        running;
      logic [31:0] pulse_count;
   } rsp_word_type;

   function automatic logic [3:0] phase_lookup(input logic [1:0] mode, input logic [2:0] idx);
      logic [3:0] pattern;
      pattern = 4'h0;
      case (mode)
         MODE_TWO_WIRE: begin
            case (idx[1:0])
               2'd0:    pattern = 4'h2;
               2'd1:    pattern = 4'h3;
               2'd2:    pattern = 4'h1;
               default: pattern = 4'h0;
            endcase
         end
         MODE_SINGLE: begin
            case (idx[1:0])
               2'd0:    pattern = 4'h1;
               2'd1:    pattern = 4'h4;
               2'd2:    pattern = 4'h2;
               default: pattern = 4'h8;
            endcase
         end
         MODE_DOUBLE: begin
            case (idx[1:0])
               2'd0:    pattern = 4'h5;
               2'd1:    pattern = 4'h6;
               2'd2:    pattern = 4'hA;
               default: pattern = 4'h9;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    pattern = 4'h1;
               3'd1:    pattern = 4'h5;
               3'd2:    pattern = 4'h4;
               3'd3:    pattern = 4'h6;
               3'd4:    pattern = 4'h2;
               3'd5:    pattern = 4'hA;
               3'd6:    pattern = 4'h8;
               default: pattern = 4'h9;
            endcase
         end
      endcase
      return pattern;
   endfunction

endpackage

// ===== design/stepper_phase_sequencer_unit.sv =====
// stepper phase sequencer: request register, step logic, response register, csr port
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | operation, pulse_target
//   rsp     | out       | rsp_valid / rsp_stall  | phase_bits, step_taken, finished,
//           |           |                        | running, pulse_count
//   csr     | in        | psel / penable / pready| paddr, pwdata, prdata
//
// one word per cycle sustained while rsp_stall is low; rsp valid follows the req accept
// through the request register and then the response register around the step logic
// synchronous active-high reset: timer stopped, coils off, csr at defaults
// a stalled response holds; the request register still takes one more word
module stepper_phase_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_pulse_target,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_phase_bits,
   output logic        rsp_step_taken,
   output logic        rsp_finished,
   output logic        rsp_running,
   output logic [31:0] rsp_pulse_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [1:0]  drive_mode_ff;
   logic        direction_ff;
   logic [15:0] step_period_ff;

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_op_ff;
   logic [31:0] in_target_ff;

   logic [15:0] tick_count_ff, tick_count_in;
   logic [2:0]  step_index_ff, step_index_in;
   logic [31:0] steps_done_ff, steps_done_in;
   logic [31:0] steps_wanted_ff, steps_wanted_in;
   logic        active_ff, active_in;
   logic [3:0]  coil_drive_ff, coil_drive_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   sps_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic        req_accept, exec, csr_write;
   logic [1:0]  csr_index;
   logic [15:0] tick_next;
   logic [2:0]  idx_next;
   logic [31:0] done_next;
   logic        stepped, reached;

   // csr port
   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      unique case (csr_index)
         sps_pkg::REG_DRIVE_MODE:  prdata = {30'd0, drive_mode_ff};
         sps_pkg::REG_DIRECTION:   prdata = {31'd0, direction_ff};
         sps_pkg::REG_STEP_PERIOD: prdata = {16'd0, step_period_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff  <= sps_pkg::MODE_TWO_WIRE;
         direction_ff   <= 1'b0;
         step_period_ff <= sps_pkg::STEP_PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sps_pkg::REG_DRIVE_MODE:  drive_mode_ff  <= pwdata[1:0];
            sps_pkg::REG_DIRECTION:   direction_ff   <= pwdata[0];
            sps_pkg::REG_STEP_PERIOD: step_period_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign exec        = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall   = in_valid_ff & rsp_valid_ff & rsp_stall;
   assign req_accept  = req_valid & ~req_stall;
   assign in_valid_in = req_accept | (in_valid_ff & ~exec);
   assign rsp_valid_in = exec | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff     <= req_operation;
         in_target_ff <= req_pulse_target;
      end
      if (exec) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // step logic
   always_comb begin
      tick_next = tick_count_ff + 16'd1;
      done_next = steps_done_ff + 32'd1;
      if (drive_mode_ff == sps_pkg::MODE_HALF_STEP) begin
         idx_next = direction_ff ? step_index_ff - 3'd1 : step_index_ff + 3'd1;
      end else begin
         idx_next = {1'b0, direction_ff ? step_index_ff[1:0] - 2'd1
                                        : step_index_ff[1:0] + 2'd1};
      end

      tick_count_in   = tick_count_ff;
      step_index_in   = step_index_ff;
      steps_done_in   = steps_done_ff;
      steps_wanted_in = steps_wanted_ff;
      active_in       = active_ff;
      coil_drive_in   = coil_drive_ff;
      stepped         = 1'b0;
      reached         = 1'b0;

      case (in_op_ff)
         sps_pkg::OP_TICK: begin
            if (active_ff) begin
               tick_count_in = tick_next;
               if (tick_next >= step_period_ff) begin
                  tick_count_in = 16'd0;
                  step_index_in = idx_next;
                  steps_done_in = done_next;
                  coil_drive_in = sps_pkg::phase_lookup(drive_mode_ff, idx_next);
                  stepped       = 1'b1;
                  if (steps_wanted_ff != 32'd0 && done_next >= steps_wanted_ff) begin
                     active_in = 1'b0;
                     reached   = 1'b1;
                  end
               end
            end
         end
         sps_pkg::OP_START: begin
            if (step_period_ff >= sps_pkg::STEP_PERIOD_MIN) begin
               tick_count_in   = 16'd0;
               steps_wanted_in = in_target_ff;
               steps_done_in   = 32'd0;
               active_in       = 1'b1;
            end
         end
         sps_pkg::OP_BREAK: active_in = 1'b0;
         default:           coil_drive_in = 4'h0;
      endcase

      rsp_word_in.phase_bits  = coil_drive_in;
      rsp_word_in.step_taken  = stepped;
      rsp_word_in.finished    = reached;
      rsp_word_in.running     = active_in;
      rsp_word_in.pulse_count = steps_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= 16'd0;
         step_index_ff   <= 3'd0;
         steps_done_ff   <= 32'd0;
         steps_wanted_ff <= 32'd0;
         active_ff       <= 1'b0;
         coil_drive_ff   <= 4'h0;
      end else if (exec) begin
         tick_count_ff   <= tick_count_in;
         step_index_ff   <= step_index_in;
         steps_done_ff   <= steps_done_in;
         steps_wanted_ff <= steps_wanted_in;
         active_ff       <= active_in;
         coil_drive_ff   <= coil_drive_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phase_bits  = rsp_word_ff.phase_bits;
   assign rsp_step_taken  = rsp_word_ff.step_taken;
   assign rsp_finished    = rsp_word_ff.finished;
   assign rsp_running     = rsp_word_ff.running;
   assign rsp_pulse_count = rsp_word_ff.pulse_count;

`ifndef NO_ASSERTIONS
   a_finish_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.finished |-> rsp_word_ff.step_taken && !rsp_word_ff.running)
      else $error("finished word without a step or still running");

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free slot");

   a_step_clears_tick: assert property (@(posedge clock) disable iff (reset)
      exec && stepped |=> tick_count_ff == 16'd0)
      else $error("tick counter not cleared after a step");

   a_idle_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      exec && !active_ff && in_op_ff == sps_pkg::OP_TICK |=> $stable(steps_done_ff)
         && $stable(step_index_ff))
      else $error("tick while stopped changed the sequencer");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      exec && stepped && drive_mode_ff != sps_pkg::MODE_HALF_STEP |=> !step_index_ff[2])
      else $error("phase index beyond a four-entry table");
`endif

endmodule

// ===== test/tb_stepper_phase_sequencer_unit.sv =====
// testbench for the stepper phase sequencer: directed and random words checked against a predictor
`timescale 1ns / 1ps

module tb_stepper_phase_sequencer_unit;

   localparam int          CYCLE_LIMIT = 400000;
   localparam logic [1:0]  REG_UNUSED  = 2'd3;
   localparam logic [0:3][0:7][3:0] COIL_TABLE = {
      32'h2310_0000, 32'h1428_0000, 32'h56A9_0000, 32'h1546_2A89
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = sps_pkg::OP_TICK;
   logic [31:0] req_pulse_target = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_phase_bits;
   logic        rsp_step_taken;
   logic        rsp_finished;
   logic        rsp_running;
   logic [31:0] rsp_pulse_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // register shadow and sequencer state
   logic [1:0]  mode_q = sps_pkg::MODE_TWO_WIRE;
   logic        dir_q = 1'b0;
   logic [15:0] period_q = sps_pkg::STEP_PERIOD_RESET;
   logic [15:0] tick_cnt = 16'd0;
   logic [2:0]  phase_idx = 3'd0;
   logic [31:0] pulses = 32'd0;
   logic [31:0] pulse_goal = 32'd0;
   logic        moving = 1'b0;
   logic [3:0]  coils = 4'd0;

   sps_pkg::rsp_word_type expected_words[$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   stepper_phase_sequencer_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_pulse_target(req_pulse_target),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_phase_bits(rsp_phase_bits), .rsp_step_taken(rsp_step_taken),
      .rsp_finished(rsp_finished), .rsp_running(rsp_running),
      .rsp_pulse_count(rsp_pulse_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic sps_pkg::rsp_word_type predict_word(logic [1:0] op, logic [31:0] target);
      sps_pkg::rsp_word_type w;
      int size;
      int idx;
      w.step_taken = 1'b0;
      w.finished = 1'b0;
      case (op)
         sps_pkg::OP_TICK: begin
            if (moving) begin
               tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt >= period_q) begin
                  tick_cnt = 16'd0;
                  size = (mode_q == sps_pkg::MODE_HALF_STEP) ? 8 : 4;
                  idx = phase_idx % size;
                  if (!dir_q) idx = (idx + 1 == size) ? 0 : idx + 1;
                  else idx = (idx == 0) ? size - 1 : idx - 1;
                  phase_idx = idx[2:0];
                  pulses = pulses + 32'd1;
                  coils = COIL_TABLE[mode_q][phase_idx];
                  w.step_taken = 1'b1;
                  if (pulse_goal != 0 && pulses >= pulse_goal) begin
                     moving = 1'b0;
                     w.finished = 1'b1;
                  end
               end
            end
         end
         sps_pkg::OP_START: begin
            if (period_q >= sps_pkg::STEP_PERIOD_MIN) begin
               tick_cnt = 16'd0;
               pulse_goal = target;
               pulses = 32'd0;
               moving = 1'b1;
            end
         end
         sps_pkg::OP_BREAK: moving = 1'b0;
         default: coils = 4'd0;
      endcase
      w.phase_bits = coils;
      w.running = moving;
      w.pulse_count = pulses;
      return w;
   endfunction

   task automatic send_word(logic [1:0] op, logic [31:0] target);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_pulse_target <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(predict_word(op, target));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] reg_sel, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (reg_sel)
         sps_pkg::REG_DRIVE_MODE:  mode_q = value[1:0];
         sps_pkg::REG_DIRECTION:   dir_q = value[0];
         sps_pkg::REG_STEP_PERIOD: period_q = value[15:0];
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      sps_pkg::rsp_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word");
            fail_count++;
         end else begin
            w = expected_words.pop_front();
            check_field("phase_bits", 32'(w.phase_bits), 32'(rsp_phase_bits));
            check_field("step_taken", 32'(w.step_taken), 32'(rsp_step_taken));
            check_field("finished", 32'(w.finished), 32'(rsp_finished));
            check_field("running", 32'(w.running), 32'(rsp_running));
            check_field("pulse_count", w.pulse_count, rsp_pulse_count);
         end
      end
   end

   task automatic test_idle_commands();
      send_word(sps_pkg::OP_TICK, 32'd0);
      send_word(sps_pkg::OP_BREAK, 32'hFFFF_FFFF);
      send_word(sps_pkg::OP_RELEASE, 32'd0);
   endtask

   task automatic test_short_period();
      settle();
      csr_write(sps_pkg::REG_STEP_PERIOD, 32'd1);
      send_word(sps_pkg::OP_START, 32'd4);
      send_word(sps_pkg::OP_TICK, 32'd0);
      settle();
      csr_write(REG_UNUSED, $urandom);
      csr_write(sps_pkg::REG_STEP_PERIOD, 32'd0);
      send_word(sps_pkg::OP_START, 32'd2);
   endtask

   task automatic test_stepping_and_finish();
      settle();
      csr_write(sps_pkg::REG_DRIVE_MODE, 32'(sps_pkg::MODE_HALF_STEP));
      csr_write(sps_pkg::REG_DIRECTION, 32'd0);
      csr_write(sps_pkg::REG_STEP_PERIOD, 32'(sps_pkg::STEP_PERIOD_MIN));
      send_word(sps_pkg::OP_START, 32'd3);
      repeat (6) send_word(sps_pkg::OP_TICK, $urandom);
   endtask

   task automatic test_restart_break_release();
      send_word(sps_pkg::OP_START, 32'hFFFF_FFFF);
      repeat (2) send_word(sps_pkg::OP_TICK, 32'd0);
      send_word(sps_pkg::OP_START, 32'd0);
      send_word(sps_pkg::OP_RELEASE, 32'hFFFF_FFFF);
      repeat (2) send_word(sps_pkg::OP_TICK, 32'd0);
      send_word(sps_pkg::OP_BREAK, 32'd0);
      send_word(sps_pkg::OP_TICK, 32'd0);
   endtask

   task automatic test_mode_change_wrap();
      settle();
      csr_write(sps_pkg::REG_DIRECTION, 32'd1);
      send_word(sps_pkg::OP_START, 32'd0);
      repeat (2) send_word(sps_pkg::OP_TICK, 32'd0);
      settle();
      // index beyond the four-entry table, running with a period below minimum
      csr_write(sps_pkg::REG_DRIVE_MODE, 32'(sps_pkg::MODE_SINGLE));
      csr_write(sps_pkg::REG_STEP_PERIOD, 32'd1);
      repeat (2) send_word(sps_pkg::OP_TICK, 32'd0);
      send_word(sps_pkg::OP_BREAK, 32'd0);
   endtask

   task automatic test_random_traffic();
      int pick;
      logic [31:0] target;
      logic [15:0] period;
      for (int blk = 0; blk < 10; blk++) begin
         settle();
         if (blk < 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 77;
         end else if (blk < 6) begin
            send_idle_pct = 77;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (blk)
            0:       period = sps_pkg::STEP_PERIOD_MIN;
            3:       period = 16'hFFFF;
            6:       period = 16'd1;
            9:       period = 16'd0;
            default: period = 16'($urandom_range(2, 6));
         endcase
         csr_write(sps_pkg::REG_DRIVE_MODE, blk % 4);
         csr_write(sps_pkg::REG_DIRECTION, (blk >> 2) & 1);
         csr_write(sps_pkg::REG_STEP_PERIOD, {16'($urandom_range(65535)), period});
         for (int n = 0; n < 70; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               case ($urandom_range(9))
                  0, 1:    target = 32'd0;
                  2:       target = $urandom;
                  default: target = $urandom_range(1, 12);
               endcase
               send_word(sps_pkg::OP_START, target);
            end else if (pick < 12) begin
               send_word(sps_pkg::OP_BREAK, $urandom);
            end else if (pick < 17) begin
               send_word(sps_pkg::OP_RELEASE, $urandom);
            end else begin
               send_word(sps_pkg::OP_TICK, $urandom);
            end
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 18;
      recv_idle_pct = 77;
      test_idle_commands();
      test_short_period();
      test_stepping_and_finish();
      test_restart_break_release();
      test_mode_change_wrap();
      test_random_traffic();
      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/sps_pkg.sv
design/stepper_phase_sequencer_unit.sv
test/tb_stepper_phase_sequencer_unit.sv
